/* rtl/apc_pkg.sv */
// shared types and constants for the amicable pair checker
package apc_pkg;

  // default width of the numbers that are tested
  localparam int unsigned NUMBER_WIDTH_DEF = 16;
  // width of the candidate and limit ports
  localparam int unsigned CAND_W           = 16;
  // width of the divisor sum port
  localparam int unsigned DIVISOR_SUM_W    = 18;
  // limit after reset
  localparam logic [CAND_W-1:0] LIMIT_RESET = 16'd30000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new candidate, start the first scan
    logic div_step;  // one step of the divider
    logic next_div;  // accumulate this divisor and start the next division
    logic save_sum;  // latch the first scan's total as the result sum
    logic second;    // start the scan of the partner number
    logic finish;    // latch the amicable flag
    logic hit;       // flag value for finish
  } apc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_last;   // divider is in its final step
    logic q_lt_d;     // quotient below divisor, so d*d > n and the scan ends
    logic pair_ok;    // candidate and its sum are in range for a partner test
    logic sum_match;  // partner's sum equals the candidate
  } apc_status_t;

endpackage

/* rtl/apc_datapath.sv */
// datapath: limit register, restoring divider, divisor accumulator, result registers
module apc_datapath import apc_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAND_W-1:0]        pair_limit_i,
  input  logic [CAND_W-1:0]        candidate_i,
  input  apc_cmd_t                 cmd_i,
  output apc_status_t              status_o,
  output logic [DIVISOR_SUM_W-1:0] divisor_sum_o,
  output logic                     is_amicable_o
);

  // numbers never exceed the 16-bit ports
  localparam int unsigned NumW = (NUMBER_WIDTH < CAND_W) ? NUMBER_WIDTH : CAND_W;
  localparam int unsigned SumW = NumW + 2;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] limit_q;
  logic [NumW-1:0] cand_q, cand_d;
  logic [NumW-1:0] n_q, n_d;
  logic [NumW-1:0] d_q, d_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] total_q, total_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            am_q, am_d;

  logic [NumW:0]   shifted;
  logic [NumW:0]   trial;
  logic [SumW-1:0] add_q;

  // limit register, reset to the default bound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET[NumW-1:0];
    end else if (cfg_we_i) begin
      limit_q <= pair_limit_i[NumW-1:0];
    end
  end

  // one restoring division step
  assign shifted = {rem_q, quo_q[NumW-1]};
  assign trial   = shifted - {1'b0, d_q};

  // cofactor counts only when it differs from the divisor
  assign add_q = (quo_q != d_q) ? SumW'(quo_q) : '0;

  always_comb begin
    cand_d  = cand_q;
    n_d     = n_q;
    d_d     = d_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    sum_d   = sum_q;
    am_d    = am_q;
    if (cmd_i.load) begin
      cand_d  = candidate_i[NumW-1:0];
      n_d     = candidate_i[NumW-1:0];
      d_d     = NumW'(2);
      rem_d   = '0;
      quo_d   = candidate_i[NumW-1:0];
      cnt_d   = CntW'(NumW);
      total_d = SumW'(1);
    end
    if (cmd_i.div_step) begin
      if (!trial[NumW]) begin
        rem_d = trial[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.next_div) begin
      if (rem_q == '0) begin
        total_d = total_q + SumW'(d_q) + add_q;
      end
      d_d   = d_q + NumW'(1);
      rem_d = '0;
      quo_d = n_q;
      cnt_d = CntW'(NumW);
    end
    if (cmd_i.save_sum) begin
      sum_d = total_q;
    end
    if (cmd_i.second) begin
      n_d     = total_q[NumW-1:0];
      d_d     = NumW'(2);
      rem_d   = '0;
      quo_d   = total_q[NumW-1:0];
      cnt_d   = CntW'(NumW);
      total_d = SumW'(1);
    end
    if (cmd_i.finish) begin
      am_d = cmd_i.hit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    n_q     <= n_d;
    d_q     <= d_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    total_q <= total_d;
    sum_q   <= sum_d;
    am_q    <= am_d;
  end

  // status to the controller
  assign status_o.div_last  = (cnt_q == CntW'(1));
  assign status_o.q_lt_d    = (quo_q < d_q);
  assign status_o.pair_ok   = (n_q < limit_q) && (SumW'(n_q) < total_q)
                              && (total_q <= SumW'(limit_q));
  assign status_o.sum_match = (total_q == SumW'(cand_q));

  assign divisor_sum_o = DIVISOR_SUM_W'(sum_q);
  assign is_amicable_o = am_q;

endmodule

/* rtl/apc_controller.sv */
// controller: sequences the two divisor scans and the result strobe
module apc_controller import apc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        result_valid_o,
  input  apc_status_t status_i,
  output apc_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_CHK
  } state_e;

  state_e state_q, state_d;
  logic   scan2_q, scan2_d;
  logic   valid_q, valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    scan2_d = scan2_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          scan2_d    = 1'b0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!status_i.q_lt_d) begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_DIV;
        end else if (!scan2_q) begin
          state_d = ST_CHK;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.hit    = status_i.sum_match;
          valid_d      = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_CHK: begin
        cmd_o.save_sum = 1'b1;
        if (status_i.pair_ok) begin
          cmd_o.second = 1'b1;
          scan2_d      = 1'b1;
          state_d      = ST_DIV;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.hit    = 1'b0;
          valid_d      = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan2_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan2_q <= scan2_d;
      valid_q <= valid_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

endmodule

/* rtl/amicable_pair_checker_unit.sv */
// Amicable pair checker. A word is taken when start is high and busy is low; the
// aliquot sum of the candidate (1 plus every divisor d with d*d <= n and its
// cofactor where that differs from d) comes out with a flag that marks the candidate
// as the smaller member of an amicable pair whose candidate is below pair_limit and
// whose partner is at most pair_limit. The result is shown for one cycle under
// result_valid_o and cannot be held off, so the receiver must take it then; the
// result ports may change while the next word is worked on. The candidate n is scanned
// first and the partner s only when it is in range: every trial divisor goes through
// one shared restoring divider, one quotient bit a cycle, and is then accumulated.
// The user must write pair_limit only while idle; the block does not enforce this.
module amicable_pair_checker_unit import apc_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAND_W-1:0]        pair_limit_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [CAND_W-1:0]        candidate_i,
  output logic                     result_valid_o,
  output logic [DIVISOR_SUM_W-1:0] divisor_sum_o,
  output logic                     is_amicable_o
);

  apc_cmd_t    cmd;
  apc_status_t status;

  // sequencing
  apc_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // arithmetic
  apc_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .pair_limit_i  (pair_limit_i),
    .candidate_i   (candidate_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .divisor_sum_o (divisor_sum_o),
    .is_amicable_o (is_amicable_o)
  );

endmodule

/* tb/sv/tb_amicable_pair_checker_unit.sv */
// self-checking testbench for the amicable pair checker unit
module tb_amicable_pair_checker_unit;
  import apc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 60000;
  localparam int unsigned SUM_SAT     = 262143;

  typedef struct {
    logic [DIVISOR_SUM_W-1:0] divisor_sum;
    logic                     is_amicable;
  } aliquot_result_t;

  // known amicable members, both sides, plus one whose partner is out of range
  localparam int unsigned AMICABLE_N = 17;
  localparam int unsigned AMICABLE_SET [AMICABLE_N] = '{
    220, 284, 1184, 1210, 2620, 2924, 5020, 5564, 6232, 6368,
    10744, 10856, 12285, 14595, 17296, 18416, 63020
  };

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CAND_W-1:0]        pair_limit_i = '0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic [CAND_W-1:0]        candidate_i  = '0;
  logic                     result_valid_o;
  logic [DIVISOR_SUM_W-1:0] divisor_sum_o;
  logic                     is_amicable_o;

  logic [CAND_W-1:0] pending_numbers[$];
  aliquot_result_t   predicted_results[$];
  logic [CAND_W-1:0] limit_model  = LIMIT_RESET;
  int unsigned       idle_pct     = 0;
  int unsigned       error_count  = 0;
  int unsigned       stall_cycles = 0;

  amicable_pair_checker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .pair_limit_i   (pair_limit_i),
    .start          (start),
    .busy           (busy),
    .candidate_i    (candidate_i),
    .result_valid_o (result_valid_o),
    .divisor_sum_o  (divisor_sum_o),
    .is_amicable_o  (is_amicable_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 1 plus every divisor d with d*d <= n and its distinct cofactor
  function automatic int unsigned aliquot_sum(input int unsigned n);
    int unsigned total;
    int unsigned d;
    total = 1;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        total += d;
        if (n / d != d) total += n / d;
      end
    end
    return total;
  endfunction

  // divisor sum and smaller-member flag for one candidate word
  function automatic aliquot_result_t predict_pair(input logic [CAND_W-1:0] cand,
                                                   input logic [CAND_W-1:0] lim);
    aliquot_result_t r;
    int unsigned n;
    int unsigned s;
    n = cand;
    s = aliquot_sum(n);
    r.is_amicable = 1'b0;
    if (n < lim && n < s && s <= lim) r.is_amicable = (aliquot_sum(s) == n);
    r.divisor_sum = (s > SUM_SAT) ? DIVISOR_SUM_W'(SUM_SAT) : DIVISOR_SUM_W'(s);
    return r;
  endfunction

  // random candidate, biased toward amicable members and small numbers
  function automatic logic [CAND_W-1:0] pick_candidate();
    case ($urandom_range(9))
      0, 1:    return CAND_W'(AMICABLE_SET[$urandom_range(AMICABLE_N - 1)]);
      2:       return CAND_W'($urandom_range(1, 300));
      3, 4, 5: return CAND_W'($urandom_range(1, 4095));
      default: return CAND_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // driver: hold the word until taken, then maybe idle before the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predicted_results.push_back(predict_pair(candidate_i, limit_model));
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_numbers.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start       <= 1'b1;
        candidate_i <= pending_numbers.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result sum %0d flag %0b", $time, divisor_sum_o,
                 is_amicable_o);
        error_count++;
      end else begin
        if (divisor_sum_o !== predicted_results[0].divisor_sum) begin
          $display("%0t: divisor_sum expected %0d actual %0d", $time,
                   predicted_results[0].divisor_sum, divisor_sum_o);
          error_count++;
        end
        if (is_amicable_o !== predicted_results[0].is_amicable) begin
          $display("%0t: is_amicable expected %0b actual %0b", $time,
                   predicted_results[0].is_amicable, is_amicable_o);
          error_count++;
        end
        void'(predicted_results.pop_front());
      end
    end
  end

  // watchdog on cycles with no word taken and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("amicable_pair_checker_unit regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // write the limit register while the unit is idle
  task automatic load_limit(input logic [CAND_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    pair_limit_i <= value;
    limit_model  = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every word is taken and every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_numbers.size() != 0 || start || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_numbers.push_back(pick_candidate());
  endtask

  // stimulus phases
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero and one, primes, squares, perfect numbers, pairs, field extremes
    idle_pct = 0;
    pending_numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd16, 16'd25,
                        16'd28, 16'd220, 16'd284, 16'd1184, 16'd1210, 16'd12285,
                        16'd14595, 16'd17296, 16'd29999, 16'd30000, 16'd32768,
                        16'd65521, 16'd65534, 16'd65535};
    wait_drained();

    // partner sum exactly at the limit, then one above it
    load_limit(16'd18416);
    pending_numbers = '{16'd17296, 16'd18416};
    wait_drained();
    load_limit(16'd18415);
    pending_numbers.push_back(16'd17296);
    wait_drained();

    // limit at its maximum, sender idling often
    load_limit(16'hFFFF);
    idle_pct = 46;
    queue_random(25);
    wait_drained();

    // smallest limit, no idling
    load_limit(16'd1);
    idle_pct = 0;
    pending_numbers = '{16'd1, 16'd220};
    queue_random(4);
    wait_drained();

    // zero limit never flags
    load_limit(16'd0);
    idle_pct = 30;
    pending_numbers = '{16'd0, 16'd220, 16'd1184};
    wait_drained();

    // middle limit, moderate idling
    load_limit(16'd10000);
    queue_random(20);
    wait_drained();

    // random limit, no idling
    load_limit(CAND_W'($urandom_range(1, 65535)));
    idle_pct = 0;
    queue_random(10);
    wait_drained();

    // random limit, frequent idling
    load_limit(CAND_W'($urandom_range(1, 65535)));
    idle_pct = 46;
    queue_random(10);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("amicable_pair_checker_unit regression: pass");
    end else begin
      $display("amicable_pair_checker_unit regression: fail");
    end
    $finish;
  end

endmodule
